>>> hdl/ltfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltfe_pkg
// Shared geometry, opcodes, beat types and memory port bundles for the
// page-organised LCD text engine.
// ----------------------------------------------------------------------------
package ltfe_pkg;

   // display and font geometry
   localparam int GLYPH_COUNT   = 96;
   localparam int GLYPH_COLUMNS = 12;
   localparam int PAGE_WIDTH    = 128;

   localparam int GLYPH_BYTES = 1 + 2 * GLYPH_COLUMNS;
   localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_BYTES;
   localparam int FRAME_DEPTH = 4 * PAGE_WIDTH;
   localparam int LINE_BYTES  = 2 * PAGE_WIDTH;
   localparam int FIRST_CODE  = 32;

   // derived widths
   localparam int GLYPH_AW   = $clog2(STORE_DEPTH);
   localparam int FRAME_AW   = $clog2(FRAME_DEPTH);
   localparam int COL_W      = $clog2(PAGE_WIDTH);
   localparam int STEP_W     = $clog2(GLYPH_BYTES);
   localparam int DRAW_COL_W = $clog2(256 + GLYPH_COLUMNS);

   // display link command bytes
   localparam logic [7:0] CMD_COL_LOW   = 8'h00;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
   localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
   localparam logic [7:0] CURSOR_MAX    = 8'hFF;
   localparam logic [3:0] CMD_BYTES     = 4'd3;

   typedef enum logic [1:0] {
      OP_DRAW  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_FLUSH = 2'd2,
      OP_LOAD  = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic        line_select;
      logic [7:0]  char_code;
      logic        restart_cursor;
      logic [11:0] font_address;
      logic [7:0]  font_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] payload;
      logic [3:0]  byte_count;
      logic        is_data;
      logic        last;
      logic [7:0]  cursor_column;
      logic        bad_char;
   } rsp_type;

   // memory port bundles, controller to RAM
   typedef struct packed {
      logic                wr_en;
      logic [FRAME_AW-1:0] wr_addr;
      logic [7:0]          wr_data;
      logic [FRAME_AW-1:0] rd_addr;
   } frame_mem_type;

   typedef struct packed {
      logic                wr_en;
      logic [GLYPH_AW-1:0] wr_addr;
      logic [7:0]          wr_data;
      logic [GLYPH_AW-1:0] rd_addr;
   } glyph_mem_type;

endpackage
`default_nettype wire

>>> hdl/lcd_text_framebuffer_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_text_framebuffer_engine
// Text engine for a page-organised monochrome LCD: glyph store, framebuffer,
// per-line cursors and page flush to the display link.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; one command is in
// work at a time. Every result beat is shown on rsp_item for exactly one cycle
// with rsp_strobe high and cannot be held off, so the receiver must take it
// then. The framebuffer RAM moves one byte a cycle. After reset busy stays
// high for a clearing pass of the framebuffer. A font byte is written when
// the load is taken, its acknowledge beat following in the cycle after. A draw
// reads the 25-byte glyph record, the advance width and then the column pairs
// (a code outside the glyph range is acknowledged without a record read, busy
// staying low). A line clear zeroes the line's 256 bytes. A flush gives 34
// beats: per page one command beat and sixteen data beats of eight bytes.
// ----------------------------------------------------------------------------
module lcd_text_framebuffer_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire ltfe_pkg::req_type req_item,
   output      logic              rsp_strobe,
   output      ltfe_pkg::rsp_type rsp_item
);

   import ltfe_pkg::*;

   frame_mem_type frame_ctl;
   glyph_mem_type glyph_ctl;
   logic [7:0]    frame_rd_data;
   logic [7:0]    glyph_rd_data;

   // sequencer
   ltfe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .frame_ctl     (frame_ctl),
      .frame_rd_data (frame_rd_data),
      .glyph_ctl     (glyph_ctl),
      .glyph_rd_data (glyph_rd_data)
   );

   // framebuffer, page after page
   ltfe_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_ctl.wr_en),
      .wr_addr (frame_ctl.wr_addr),
      .wr_data (frame_ctl.wr_data),
      .rd_addr (frame_ctl.rd_addr),
      .rd_data (frame_rd_data)
   );

   // glyph records
   ltfe_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (glyph_ctl.wr_en),
      .wr_addr (glyph_ctl.wr_addr),
      .wr_data (glyph_ctl.wr_data),
      .rd_addr (glyph_ctl.rd_addr),
      .rd_data (glyph_rd_data)
   );

   // a font load is acknowledged on the very next cycle
   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.opcode == OP_LOAD) |=> (rsp_strobe && rsp_item.last))
      else $error("font load not acknowledged next cycle");

   // clear and flush hold the block busy after they are taken
   a_long_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.opcode == OP_CLEAR || req_item.opcode == OP_FLUSH))
      |=> busy)
      else $error("clear or flush did not raise busy");

   // the final beat of a command leaves the block ready
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last) |-> !busy)
      else $error("final beat while still busy");

   // data beats carry bytes and never flag a bad character
   a_data_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.is_data) |-> (rsp_item.byte_count != 4'd0 && !rsp_item.bad_char))
      else $error("malformed data beat");

endmodule
`default_nettype wire

>>> hdl/ltfe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltfe_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ltfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/ltfe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltfe_ctrl
// Sequencer for the text engine: clearing pass, glyph copy, line clear,
// page flush and font loading around the frame and glyph RAMs.
// ----------------------------------------------------------------------------
module ltfe_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output      logic                    busy,
   input  wire ltfe_pkg::req_type       req_item,
   output      logic                    rsp_strobe,
   output      ltfe_pkg::rsp_type       rsp_item,
   output      ltfe_pkg::frame_mem_type frame_ctl,
   input  wire logic [7:0]              frame_rd_data,
   output      ltfe_pkg::glyph_mem_type glyph_ctl,
   input  wire logic [7:0]              glyph_rd_data
);

   import ltfe_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_DRAW,
      ST_FLUSH_CMD,
      ST_FLUSH_DATA
   } state_type;

   state_type             state_ff, state_in;
   logic [FRAME_AW-1:0]   sweep_ff, sweep_in;
   logic                  line_ff, line_in;
   logic [7:0]            pos_ff, pos_in;
   logic [7:0]            adv_ff, adv_in;
   logic [7:0]            cursor_one_ff, cursor_one_in;
   logic [7:0]            cursor_two_ff, cursor_two_in;
   logic [GLYPH_AW-1:0]   gaddr_ff, gaddr_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  issue_ff, issue_in;
   logic                  dvalid_ff, dvalid_in;
   logic [STEP_W-1:0]     dstep_ff, dstep_in;
   logic                  page_ff, page_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic                  fvalid_ff, fvalid_in;
   logic [COL_W-1:0]      fcol_ff, fcol_in;
   logic [63:0]           chunk_ff, chunk_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic [7:0]            cur_sel;
   logic [7:0]            cur_line;
   logic [7:0]            start_pos;
   logic                  code_bad;
   logic [7:0]            glyph_index;
   logic [STEP_W-1:0]     dj;
   logic [DRAW_COL_W-1:0] dcol;
   logic [1:0]            dpage;
   logic [8:0]            adv_sum;
   logic [7:0]            new_cursor;
   logic [2:0]            byte_idx;
   logic                  page_end;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // cursor of the requested line and of the line in progress
   assign cur_sel   = req_item.line_select ? cursor_two_ff : cursor_one_ff;
   assign cur_line  = line_ff ? cursor_two_ff : cursor_one_ff;
   assign start_pos = req_item.restart_cursor ? 8'd0 : cur_sel;

   // glyph range check and record base
   assign code_bad = (req_item.char_code < 8'(FIRST_CODE)) ||
                     (9'(req_item.char_code) >= 9'(FIRST_CODE + GLYPH_COUNT));
   assign glyph_index = req_item.char_code - 8'(FIRST_CODE);

   // column pair step -> page half and display column
   assign dj    = dstep_ff - STEP_W'(1);
   assign dcol  = DRAW_COL_W'(pos_ff) + DRAW_COL_W'(dj >> 1);
   assign dpage = {line_ff, dj[0]};

   // saturating cursor advance
   assign adv_sum    = {1'b0, pos_ff} + {1'b0, adv_ff};
   assign new_cursor = adv_sum[8] ? CURSOR_MAX : adv_sum[7:0];

   // flush byte position within the eight-byte beat
   assign byte_idx = fcol_ff[2:0];
   assign page_end = (fcol_ff == COL_W'(PAGE_WIDTH - 1));

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      line_in       = line_ff;
      pos_in        = pos_ff;
      adv_in        = adv_ff;
      cursor_one_in = cursor_one_ff;
      cursor_two_in = cursor_two_ff;
      gaddr_in      = gaddr_ff;
      step_in       = step_ff;
      issue_in      = issue_ff;
      dvalid_in     = 1'b0;
      dstep_in      = step_ff;
      page_in       = page_ff;
      col_in        = col_ff;
      fvalid_in     = 1'b0;
      fcol_in       = col_ff;
      chunk_in      = chunk_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;

      frame_ctl         = '0;
      frame_ctl.rd_addr = FRAME_AW'(32'({line_ff, page_ff}) * PAGE_WIDTH + 32'(col_ff));
      glyph_ctl         = '0;
      glyph_ctl.rd_addr = gaddr_ff;

      case (state_ff)
         // clearing pass over the whole frame store after reset
         ST_INIT: begin
            frame_ctl.wr_en   = 1'b1;
            frame_ctl.wr_addr = sweep_ff;
            sweep_in          = sweep_ff + FRAME_AW'(1);
            if (sweep_ff == FRAME_AW'(FRAME_DEPTH - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               line_in = req_item.line_select;
               case (req_item.opcode)
                  OP_DRAW: begin
                     if (req_item.restart_cursor) begin
                        if (req_item.line_select) begin
                           cursor_two_in = 8'd0;
                        end else begin
                           cursor_one_in = 8'd0;
                        end
                     end
                     if (code_bad) begin
                        rsp_strobe_in        = 1'b1;
                        rsp_in.last          = 1'b1;
                        rsp_in.cursor_column = start_pos;
                        rsp_in.bad_char      = 1'b1;
                     end else begin
                        pos_in   = start_pos;
                        gaddr_in = GLYPH_AW'(32'(glyph_index) * GLYPH_BYTES);
                        step_in  = '0;
                        issue_in = 1'b1;
                        state_in = ST_DRAW;
                     end
                  end
                  OP_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  OP_FLUSH: begin
                     page_in  = 1'b0;
                     state_in = ST_FLUSH_CMD;
                  end
                  OP_LOAD: begin
                     glyph_ctl.wr_en   = (32'(req_item.font_address) < 32'(STORE_DEPTH));
                     glyph_ctl.wr_addr = GLYPH_AW'(req_item.font_address);
                     glyph_ctl.wr_data = req_item.font_byte;
                     rsp_strobe_in        = 1'b1;
                     rsp_in.last          = 1'b1;
                     rsp_in.cursor_column = cur_sel;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // zero the line's two pages, one byte a cycle
         ST_CLEAR: begin
            frame_ctl.wr_en   = 1'b1;
            frame_ctl.wr_addr = FRAME_AW'(32'(line_ff) * LINE_BYTES + 32'(sweep_ff));
            sweep_in          = sweep_ff + FRAME_AW'(1);
            if (sweep_ff == FRAME_AW'(LINE_BYTES - 1)) begin
               sweep_in             = '0;
               rsp_strobe_in        = 1'b1;
               rsp_in.last          = 1'b1;
               rsp_in.cursor_column = cur_line;
               state_in             = ST_IDLE;
            end
         end

         // glyph record read, one byte issued a cycle, used in the cycle after its read
         ST_DRAW: begin
            if (issue_ff) begin
               dvalid_in = 1'b1;
               dstep_in  = step_ff;
               gaddr_in  = gaddr_ff + GLYPH_AW'(1);
               step_in   = step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(GLYPH_BYTES - 1)) begin
                  issue_in = 1'b0;
               end
            end
            if (dvalid_ff) begin
               if (dstep_ff == '0) begin
                  adv_in = glyph_rd_data;
               end else if (dcol < DRAW_COL_W'(PAGE_WIDTH)) begin
                  frame_ctl.wr_en   = 1'b1;
                  frame_ctl.wr_addr = FRAME_AW'(32'(dpage) * PAGE_WIDTH + 32'(dcol));
                  frame_ctl.wr_data = glyph_rd_data;
               end
               if (dstep_ff == STEP_W'(GLYPH_BYTES - 1)) begin
                  if (line_ff) begin
                     cursor_two_in = new_cursor;
                  end else begin
                     cursor_one_in = new_cursor;
                  end
                  rsp_strobe_in        = 1'b1;
                  rsp_in.last          = 1'b1;
                  rsp_in.cursor_column = new_cursor;
                  state_in             = ST_IDLE;
               end
            end
         end

         // column and page address beat ahead of each page
         ST_FLUSH_CMD: begin
            rsp_strobe_in        = 1'b1;
            rsp_in.payload       = {40'd0, CMD_PAGE_BASE + 8'({line_ff, page_ff}),
                                    CMD_COL_HIGH, CMD_COL_LOW};
            rsp_in.byte_count    = CMD_BYTES;
            rsp_in.cursor_column = cur_line;
            col_in               = '0;
            issue_in             = 1'b1;
            state_in             = ST_FLUSH_DATA;
         end

         // stream the page, packing eight bytes a beat
         ST_FLUSH_DATA: begin
            if (issue_ff) begin
               fvalid_in = 1'b1;
               fcol_in   = col_ff;
               col_in    = col_ff + COL_W'(1);
               if (col_ff == COL_W'(PAGE_WIDTH - 1)) begin
                  issue_in = 1'b0;
               end
            end
            if (fvalid_ff) begin
               chunk_in = ((byte_idx == 3'd0) ? 64'd0 : chunk_ff) |
                          (64'(frame_rd_data) << {byte_idx, 3'b000});
               if ((byte_idx == 3'd7) || page_end) begin
                  rsp_strobe_in        = 1'b1;
                  rsp_in.payload       = chunk_in;
                  rsp_in.byte_count    = 4'(byte_idx) + 4'd1;
                  rsp_in.is_data       = 1'b1;
                  rsp_in.last          = page_ff && page_end;
                  rsp_in.cursor_column = cur_line;
               end
               if (page_end) begin
                  if (page_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     page_in  = 1'b1;
                     state_in = ST_FLUSH_CMD;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         sweep_ff      <= '0;
         cursor_one_ff <= '0;
         cursor_two_ff <= '0;
         issue_ff      <= 1'b0;
         dvalid_ff     <= 1'b0;
         fvalid_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         cursor_one_ff <= cursor_one_in;
         cursor_two_ff <= cursor_two_in;
         issue_ff      <= issue_in;
         dvalid_ff     <= dvalid_in;
         fvalid_ff     <= fvalid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      line_ff  <= line_in;
      pos_ff   <= pos_in;
      adv_ff   <= adv_in;
      gaddr_ff <= gaddr_in;
      step_ff  <= step_in;
      dstep_ff <= dstep_in;
      page_ff  <= page_in;
      col_ff   <= col_in;
      fcol_ff  <= fcol_in;
      chunk_ff <= chunk_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
`default_nettype wire

>>> sim/tb_lcd_text_framebuffer_engine.sv
// ----------------------------------------------------------------------------
// tb_lcd_text_framebuffer_engine
// Self-checking bench for the LCD text engine. Command beats go in from a
// queue of pending commands through a clocked driver with random gaps. A
// clocked monitor predicts each accepted command against a local image of
// the glyph store, framebuffer and line cursors, then checks every result
// beat field by field against the oldest predicted beat.
// ----------------------------------------------------------------------------
module tb_lcd_text_framebuffer_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import ltfe_pkg::*;

   localparam int ITEM_TARGET  = 170;
   localparam int TAIL_CYCLES  = 300;
   localparam int RUN_LIMIT    = 1000000;
   localparam int REPORT_LIMIT = 10;
   localparam int FLUSH_CHUNKS = (PAGE_WIDTH + 7) / 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // predicted state of the engine
   logic [7:0] frame_img [FRAME_DEPTH];
   logic [7:0] font_img [STORE_DEPTH];
   logic [7:0] line_cursor [2];

   req_type pending_cmds [$];
   rsp_type expected_beats [$];
   int      loaded_glyphs [$];
   bit      glyph_ready [GLYPH_COUNT];

   bit beat_taken = 1'b0;
   int cmds_total = 0;
   int cmds_taken = 0;
   int mismatch_count = 0;
   int gap_left = 0;
   int burst_left = 0;

   lcd_text_framebuffer_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic rsp_type ack_beat(logic [7:0] cursor, logic bad);
      rsp_type b;
      b = '0;
      b.last = 1'b1;
      b.cursor_column = cursor;
      b.bad_char = bad;
      return b;
   endfunction

   task automatic render_command(req_type cmd);
      int line;
      int top;
      int base;
      int pos;
      int col;
      int adv;
      int page;
      int idx;
      int n;
      logic bad;
      rsp_type b;
      line = int'(cmd.line_select);
      top  = line * LINE_BYTES;
      bad  = 1'b0;
      case (cmd.opcode)
         OP_DRAW: begin
            if (cmd.restart_cursor)
               line_cursor[line] = 8'd0;
            if (cmd.char_code < FIRST_CODE || cmd.char_code >= FIRST_CODE + GLYPH_COUNT) begin
               bad = 1'b1;
            end else begin
               base = (int'(cmd.char_code) - FIRST_CODE) * GLYPH_BYTES;
               pos  = int'(line_cursor[line]);
               // columns past the line end are dropped, never wrapped
               for (int i = 0; i < GLYPH_COLUMNS; i++) begin
                  col = pos + i;
                  if (col < PAGE_WIDTH) begin
                     frame_img[top + col] = font_img[base + 1 + 2 * i];
                     frame_img[top + PAGE_WIDTH + col] = font_img[base + 2 + 2 * i];
                  end
               end
               adv = pos + int'(font_img[base]);
               line_cursor[line] = (adv > 255) ? CURSOR_MAX : 8'(adv);
            end
            expected_beats.push_back(ack_beat(line_cursor[line], bad));
         end
         OP_CLEAR: begin
            for (int i = 0; i < LINE_BYTES; i++)
               frame_img[top + i] = 8'h00;
            expected_beats.push_back(ack_beat(line_cursor[line], 1'b0));
         end
         OP_LOAD: begin
            if (cmd.font_address < STORE_DEPTH)
               font_img[cmd.font_address] = cmd.font_byte;
            expected_beats.push_back(ack_beat(line_cursor[line], 1'b0));
         end
         default: begin
            // flush: per page a column/page command, then the data bytes
            for (int p = 0; p < 2; p++) begin
               page = line * 2 + p;
               b = '0;
               b.payload = {40'd0, CMD_PAGE_BASE + 8'(page), CMD_COL_HIGH, CMD_COL_LOW};
               b.byte_count = CMD_BYTES;
               b.cursor_column = line_cursor[line];
               expected_beats.push_back(b);
               for (int c = 0; c < FLUSH_CHUNKS; c++) begin
                  b = '0;
                  n = 0;
                  for (int k = 0; k < 8; k++) begin
                     idx = c * 8 + k;
                     if (idx < PAGE_WIDTH) begin
                        b.payload = b.payload
                           | (64'(frame_img[page * PAGE_WIDTH + idx]) << (8 * k));
                        n++;
                     end
                  end
                  b.byte_count = 4'(n);
                  b.is_data = 1'b1;
                  b.last = (p == 1 && c == FLUSH_CHUNKS - 1);
                  b.cursor_column = line_cursor[line];
                  expected_beats.push_back(b);
               end
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   // monitor: take command beats into the predictor, check result beats
   always @(posedge clock) begin : monitor
      rsp_type want;
      beat_taken = !reset && start && !busy;
      if (beat_taken) begin
         render_command(req_item);
         cmds_taken++;
      end
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: result beat with none expected, got %p", $realtime, rsp_item);
         end else begin
            want = expected_beats.pop_front();
            check_field("payload", want.payload, rsp_item.payload);
            check_field("byte_count", 64'(want.byte_count), 64'(rsp_item.byte_count));
            check_field("is_data", 64'(want.is_data), 64'(rsp_item.is_data));
            check_field("last", 64'(want.last), 64'(rsp_item.last));
            check_field("cursor_column", 64'(want.cursor_column),
                        64'(rsp_item.cursor_column));
            check_field("bad_char", 64'(want.bad_char), 64'(rsp_item.bad_char));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driver: one command beat at a time, random gap before each new command
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (gap_left != 0) begin
            start <= 1'b0;
            gap_left = gap_left - 1;
         end else if (pending_cmds.size() != 0) begin
            req_item <= pending_cmds.pop_front();
            start <= 1'b1;
            // occasional bursts with no gaps at all
            if (burst_left != 0) begin
               burst_left = burst_left - 1;
               gap_left = 0;
            end else if ($urandom_range(0, 15) == 0) begin
               burst_left = $urandom_range(10, 40);
               gap_left = 0;
            end else begin
               gap_left = $urandom_range(0, 11);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_cmd(opcode_type op, int line, int code, int restart,
                           int addr, int value);
      req_type r;
      r.opcode = op;
      r.line_select = 1'(line);
      r.char_code = 8'(code);
      r.restart_cursor = 1'(restart);
      r.font_address = 12'(addr);
      r.font_byte = 8'(value);
      pending_cmds.push_back(r);
      cmds_total++;
   endtask

   // unused fields of a command carry random noise
   task automatic push_noisy(opcode_type op, int line);
      push_cmd(op, line, $urandom_range(0, 255), $urandom_range(0, 1),
               $urandom_range(0, 4095), $urandom_range(0, 255));
   endtask

   task automatic push_draw(int line, int code, int restart);
      push_cmd(OP_DRAW, line, code, restart, $urandom_range(0, 4095),
               $urandom_range(0, 255));
   endtask

   task automatic push_load(int addr, int value);
      push_cmd(OP_LOAD, $urandom_range(0, 1), $urandom_range(0, 255),
               $urandom_range(0, 1), addr, value);
   endtask

   // whole glyph record: advance width, then column pairs
   task automatic push_glyph(int glyph, int width);
      int base;
      base = glyph * GLYPH_BYTES;
      push_load(base, width);
      for (int i = 1; i < GLYPH_BYTES; i++) begin
         case ($urandom_range(0, 5))
            0: push_load(base + i, 8'h00);
            1: push_load(base + i, 8'hFF);
            default: push_load(base + i, $urandom_range(0, 255));
         endcase
      end
      if (!glyph_ready[glyph]) begin
         glyph_ready[glyph] = 1'b1;
         loaded_glyphs.push_back(glyph);
      end
   endtask

   function automatic int bad_code();
      return ($urandom_range(0, 1) != 0) ? $urandom_range(0, FIRST_CODE - 1)
                                          : $urandom_range(FIRST_CODE + GLYPH_COUNT, 255);
   endfunction

   // ------------------------------------------------------------------------
   // Reset
   // ------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // watchdog
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < RUN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      int sel;
      int line;
      for (int i = 0; i < FRAME_DEPTH; i++)
         frame_img[i] = 8'h00;
      for (int i = 0; i < STORE_DEPTH; i++)
         font_img[i] = 8'h00;
      line_cursor[0] = 8'd0;
      line_cursor[1] = 8'd0;

      // space glyph of width 120 and the last glyph of width 255
      push_glyph(0, 120);
      push_glyph(GLYPH_COUNT - 1, 255);

      // directed: line end clipping, cursor saturation, bad codes
      push_draw(0, FIRST_CODE, 1);
      push_draw(0, FIRST_CODE, 0);
      push_draw(0, FIRST_CODE, 0);
      push_draw(0, FIRST_CODE + GLYPH_COUNT - 1, 0);
      push_draw(1, FIRST_CODE + GLYPH_COUNT - 1, 1);
      push_draw(1, FIRST_CODE - 1, 0);
      push_draw(1, FIRST_CODE + GLYPH_COUNT, 1);
      push_draw(0, 0, 0);
      push_draw(0, 255, 1);
      push_noisy(OP_FLUSH, 0);
      push_noisy(OP_FLUSH, 1);
      push_noisy(OP_CLEAR, 0);
      push_noisy(OP_FLUSH, 0);
      // loads past the store end are acknowledged but ignored
      push_load(STORE_DEPTH, 8'hFF);
      push_load(4095, 8'h00);
      push_load(STORE_DEPTH - 1, 8'hA5);
      push_draw(1, FIRST_CODE + GLYPH_COUNT - 1, 1);
      push_noisy(OP_FLUSH, 1);
      push_noisy(OP_CLEAR, 1);

      // random: mostly glyph loads followed by draws, some noise
      while (cmds_total < ITEM_TARGET) begin
         sel  = $urandom_range(0, 99);
         line = $urandom_range(0, 1);
         if (sel < 10) begin
            push_glyph($urandom_range(0, GLYPH_COUNT - 1),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 14));
         end else if (sel < 16) begin
            push_load($urandom_range(0, 4095), $urandom_range(0, 255));
         end else if (sel < 70) begin
            if (loaded_glyphs.size() != 0 && $urandom_range(0, 7) != 0)
               push_draw(line,
                         FIRST_CODE + loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)],
                         ($urandom_range(0, 4) == 0));
            else
               push_draw(line, bad_code(), $urandom_range(0, 1));
         end else if (sel < 82) begin
            push_noisy(OP_CLEAR, line);
         end else begin
            push_noisy(OP_FLUSH, line);
         end
      end

      // drain: all commands taken and every predicted beat seen
      while (cmds_taken < cmds_total || expected_beats.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
